@@ hw/rtl/max_heap_priority_queue_core_assert.svh @@
// Assertion macros shared by the heap queue RTL. Each macro checks at the
// rising clock edge and is disabled while the active-low reset is asserted.
`ifndef MAX_HEAP_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define MAX_HEAP_PRIORITY_QUEUE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define MHPQ_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("heap queue check failed: implication");

// The consequent must hold in the cycle after the antecedent.
`define MHPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("heap queue check failed: next-cycle implication");

// The condition must never be seen true.
`define MHPQ_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("heap queue check failed: forbidden condition");

`else

`define MHPQ_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define MHPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define MHPQ_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

@@ hw/rtl/mhpq_pkg.sv @@
package mhpq_pkg;

	// Fixed widths of the command and result words.
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 5;

	typedef logic [1:0] op_t;
	typedef logic [1:0] status_t;

	// Operation codes.
	localparam op_t OP_INSERT = 2'd0;
	localparam op_t OP_REMOVE = 2'd1;
	localparam op_t OP_PEEK   = 2'd2;

	// Status codes.
	localparam status_t STATUS_OK        = 2'd0;
	localparam status_t STATUS_OVERFLOW  = 2'd1;
	localparam status_t STATUS_UNDERFLOW = 2'd2;

endpackage

@@ hw/rtl/max_heap_priority_queue_core.sv @@
// Binary max-heap priority queue with a command-style interface.
// A command word (op, value) is taken at a rising edge where start is high
// and busy is low. The op selects insert, remove maximum or peek maximum.
// Every command returns exactly one result word, shown on result_value,
// status and entry_count for one cycle while done is high, in the cycle
// right after the command was taken. The receiver cannot stall the result.
// Keys live in a synchronous RAM with one write and two read ports; the key
// that is being sifted stays in a register and the hole it leaves moves
// through the tree, so each level costs a read step and then a compare and
// write step. A remove first fetches the last entry (LAST_RD, LAST_LD), but
// then walks a tree that is one level shallower. Peek, error cases and the
// unused op code never raise busy. While busy is high no new command word
// is taken; how long busy stays high is bounded by the depth of the tree
// and the RAM read latency.
// Reset empties the queue at once; no clearing pass runs, since only live
// entries are ever used. A copy of the root is held in a register so that
// peek and remove answer without a RAM read.
module max_heap_priority_queue_core #(
	parameter int DEPTH     = 16,
	parameter int KEY_WIDTH = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  mhpq_pkg::op_t                         op,
	input  logic signed [mhpq_pkg::VALUE_W-1:0]   value,
	output logic                                  done,
	output logic signed [mhpq_pkg::VALUE_W-1:0]   result_value,
	output mhpq_pkg::status_t                     status,
	output logic [mhpq_pkg::COUNT_W-1:0]          entry_count
);

	import mhpq_pkg::*;

`include "max_heap_priority_queue_core_assert.svh"

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	// Child indexes reach 2*DEPTH, so they need two bits more than an index.
	localparam int CH_W  = IDX_W + 2;

	// Sequencer states.
	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_UP_CHK  = 3'd1;
	localparam logic [2:0] ST_UP_CMP  = 3'd2;
	localparam logic [2:0] ST_LAST_RD = 3'd3;
	localparam logic [2:0] ST_LAST_LD = 3'd4;
	localparam logic [2:0] ST_DN_CHK  = 3'd5;
	localparam logic [2:0] ST_DN_CMP  = 3'd6;

	logic [2:0]                  state_q, state_d;
	logic [CNT_W-1:0]            count_q, count_d;
	logic [IDX_W-1:0]            pos_q, pos_d;
	logic signed [KEY_WIDTH-1:0] key_q, key_d;
	logic signed [KEY_WIDTH-1:0] root_q;
	logic                        done_q;
	logic signed [VALUE_W-1:0]   result_q, result_d;
	status_t                     status_q, status_d;
	logic [COUNT_W-1:0]          ecount_q;

	logic                        accept;
	logic signed [KEY_WIDTH-1:0] key_in;

	// RAM port signals.
	logic                        mem_we;
	logic [IDX_W-1:0]            mem_waddr;
	logic signed [KEY_WIDTH-1:0] mem_wdata;
	logic [IDX_W-1:0]            mem_raddr_a;
	logic [IDX_W-1:0]            mem_raddr_b;
	logic signed [KEY_WIDTH-1:0] rd_a;
	logic signed [KEY_WIDTH-1:0] rd_b;

	// Tree navigation around the hole.
	logic [IDX_W-1:0]            parent_idx;
	logic [CH_W-1:0]             left_idx;
	logic [CH_W-1:0]             right_idx;
	logic                        left_live;
	logic                        right_live;
	logic                        take_right;
	logic signed [KEY_WIDTH-1:0] big_val;
	logic [IDX_W-1:0]            big_idx;

	mhpq_heap_ram #(
		.DEPTH (DEPTH),
		.WIDTH (KEY_WIDTH)
	) u_ram (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.raddr_a (mem_raddr_a),
		.raddr_b (mem_raddr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// The 32-bit command value is narrowed or sign-extended to the key width.
	assign key_in = KEY_WIDTH'(value);

	assign parent_idx = IDX_W'((pos_q - IDX_W'(1)) >> 1);
	assign left_idx   = {1'b0, pos_q, 1'b1};
	assign right_idx  = left_idx + CH_W'(1);
	assign left_live  = (left_idx < CH_W'(count_q));
	assign right_live = (right_idx < CH_W'(count_q));

	// The larger child wins; on equal keys the right child is taken.
	assign take_right = right_live && !(rd_a > rd_b);
	assign big_val    = take_right ? rd_b : rd_a;
	assign big_idx    = take_right ? right_idx[IDX_W-1:0] : left_idx[IDX_W-1:0];

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		pos_d       = pos_q;
		key_d       = key_q;
		result_d    = result_q;
		status_d    = status_q;
		mem_we      = 1'b0;
		mem_waddr   = pos_q;
		mem_wdata   = key_q;
		mem_raddr_a = pos_q;
		mem_raddr_b = pos_q;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					result_d = '0;
					status_d = STATUS_OK;
					case (op)
						OP_INSERT: begin
							if (count_q == CNT_W'(DEPTH)) begin
								status_d = STATUS_OVERFLOW;
							end else begin
								// The new key starts at the first free slot and moves up.
								key_d   = key_in;
								pos_d   = count_q[IDX_W-1:0];
								count_d = count_q + CNT_W'(1);
								state_d = ST_UP_CHK;
							end
						end
						OP_REMOVE: begin
							if (count_q == '0) begin
								status_d = STATUS_UNDERFLOW;
							end else begin
								result_d = VALUE_W'(root_q);
								count_d  = count_q - CNT_W'(1);
								// Removing the only entry leaves nothing to sift.
								if (count_q != CNT_W'(1)) begin
									state_d = ST_LAST_RD;
								end
							end
						end
						OP_PEEK: begin
							if (count_q == '0) begin
								status_d = STATUS_UNDERFLOW;
							end else begin
								result_d = VALUE_W'(root_q);
							end
						end
						default: begin
							status_d = STATUS_OK;
						end
					endcase
				end
			end
			ST_UP_CHK: begin
				if (pos_q == '0) begin
					mem_we    = 1'b1;
					mem_waddr = '0;
					mem_wdata = key_q;
					state_d   = ST_IDLE;
				end else begin
					mem_raddr_a = parent_idx;
					state_d     = ST_UP_CMP;
				end
			end
			ST_UP_CMP: begin
				mem_we = 1'b1;
				if (key_q > rd_a) begin
					// The parent moves down into the hole.
					mem_waddr = pos_q;
					mem_wdata = rd_a;
					pos_d     = parent_idx;
					state_d   = ST_UP_CHK;
				end else begin
					mem_waddr = pos_q;
					mem_wdata = key_q;
					state_d   = ST_IDLE;
				end
			end
			ST_LAST_RD: begin
				// count_q already points at the old last entry.
				mem_raddr_a = count_q[IDX_W-1:0];
				state_d     = ST_LAST_LD;
			end
			ST_LAST_LD: begin
				key_d   = rd_a;
				pos_d   = '0;
				state_d = ST_DN_CHK;
			end
			ST_DN_CHK: begin
				if (!left_live) begin
					mem_we    = 1'b1;
					mem_waddr = pos_q;
					mem_wdata = key_q;
					state_d   = ST_IDLE;
				end else begin
					mem_raddr_a = left_idx[IDX_W-1:0];
					mem_raddr_b = right_idx[IDX_W-1:0];
					state_d     = ST_DN_CMP;
				end
			end
			ST_DN_CMP: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q;
				if (big_val > key_q) begin
					// The larger child moves up into the hole.
					mem_wdata = big_val;
					pos_d     = big_idx;
					state_d   = ST_DN_CHK;
				end else begin
					mem_wdata = key_q;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= accept;
		end
	end

	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		key_q <= key_d;
		// Keep the root copy in step with every write to the top slot.
		if (mem_we && (mem_waddr == '0)) begin
			root_q <= mem_wdata;
		end
		if (accept) begin
			result_q <= result_d;
			status_q <= status_d;
			ecount_q <= COUNT_W'(count_d);
		end
	end

	assign done         = done_q;
	assign result_value = result_q;
	assign status       = status_q;
	assign entry_count  = ecount_q;

	`MHPQ_ASSERT_NEVER(a_count_range, clk, arst_n, count_q > CNT_W'(DEPTH))
	`MHPQ_ASSERT_NEXT(a_done_after_accept, clk, arst_n, accept, done)
	`MHPQ_ASSERT_IMPLIES(a_done_needs_accept, clk, arst_n, done, $past(accept))
	`MHPQ_ASSERT_IMPLIES(a_write_only_busy, clk, arst_n, mem_we, busy)
	`MHPQ_ASSERT_IMPLIES(a_count_matches, clk, arst_n, done, entry_count == COUNT_W'(count_q))

endmodule

@@ hw/rtl/mhpq_heap_ram.sv @@
module mhpq_heap_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	// One write port and two registered read ports.
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule
